// ----- rtl/jsc_pkg.sv -----
// Shared constants, reciprocal multipliers and stage payload types for the calendar converter.
package jsc_pkg;

    // Number of register stages from the input to the output register.
    localparam int STAGES = 11;

    // Accepted input window: January 1 of year 1 to December 31 of year 9999.
    localparam logic [38:0] IN_LOW  = 39'd148731206400;
    localparam logic [38:0] IN_HIGH = 39'd464269103999;

    // 86400 = 2^7 * 675: the low seven bits pass through, the rest is divided by 675.
    localparam int LOW_BITS    = 7;
    localparam int DAY_ODD_DIV = 675;

    // Reciprocals are rounded up; each shift is wide enough to keep the quotient exact
    // over the full width of the dividend.
    localparam int          SH_DAY  = 42;
    localparam logic [32:0] RCP_DAY =
        33'(((64'd1 << SH_DAY) + 64'(DAY_ODD_DIV) - 64'd1) / 64'(DAY_ODD_DIV));

    localparam logic [22:0] GREG_START   = 23'd2299161;
    localparam int          ALPHA_OFFSET = 7468865;
    localparam int          ALPHA_DIV    = 146097;
    localparam int          SH_ALPHA     = 42;
    localparam logic [24:0] RCP_ALPHA    =
        25'(((64'd1 << SH_ALPHA) + 64'(ALPHA_DIV) - 64'd1) / 64'(ALPHA_DIV));

    localparam int          SECS_PER_MIN = 60;
    localparam int          SH_SEC       = 23;
    localparam logic [17:0] RCP_SEC      =
        18'(((64'd1 << SH_SEC) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));
    localparam int          SH_MIN       = 17;
    localparam logic [11:0] RCP_MIN      =
        12'(((64'd1 << SH_MIN) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

    localparam int          B_BIAS   = 1524;
    localparam int          C_OFFSET = 2442;
    localparam int          C_DIV    = 7305;
    localparam int          SH_C     = 40;
    localparam logic [27:0] RCP_C    =
        28'(((64'd1 << SH_C) + 64'(C_DIV) - 64'd1) / 64'(C_DIV));

    // Month index E = floor(10000 * (B - D) / 306001), folded into one multiplier.
    localparam int          SH_E  = 28;
    localparam logic [23:0] RCP_E = 24'(((64'd10000 << SH_E) + 64'd306000) / 64'd306001);

    // floor(30.6001 * E) for every four-bit month index.
    localparam logic [8:0] DAY_OFFSET [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    localparam int YEAR_LATE  = 4716;
    localparam int YEAR_EARLY = 4715;

    localparam int          CENT_OFFSET = 4899;
    localparam int          LEAP_OFFSET = 4799;
    localparam int          CENT_DIV    = 100;
    localparam int          SH_CENT     = 22;
    localparam logic [15:0] RCP_CENT    =
        16'(((64'd1 << SH_CENT) + 64'(CENT_DIV) - 64'd1) / 64'(CENT_DIV));

    // Day of year is z - jan1 + 1, and only its low nine bits are kept.
    localparam logic [8:0] DOY_BIAS = 9'(32075 - 336);

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] weekday;
    } tod_t;

    typedef struct packed {
        logic        oor;
        logic        greg;
        logic [22:0] z;
        logic [23:0] ax;
        logic [16:0] sod;
        logic [5:0]  wsum;
    } split_t;

    typedef struct packed {
        logic        oor;
        logic [8:0]  z_lo;
        logic [8:0]  b_lo;
        logic [26:0] cx;
        tod_t        tod;
    } adj_t;

    typedef struct packed {
        logic        oor;
        logic [8:0]  z_lo;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        tod_t        tod;
    } ymd_t;

    typedef struct packed {
        logic        oor;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        tod_t        tod;
        logic [8:0]  day_of_year;
    } result_t;

endpackage

// ----- rtl/jsc_day_split.sv -----
// Stages one and two: splits the second count into day number and second of day.
module jsc_day_split (
    input  logic             aclk,
    input  logic [1:0]       stage_en,
    input  logic [38:0]      seconds_count,
    output jsc_pkg::split_t  split
);

    logic              oor_next, oor_reg;
    logic [6:0]        lo_next, lo_reg;
    logic [31:0]       x_next, x_reg;
    logic [22:0]       zq_next, zq_reg;
    logic [64:0]       day_prod;
    jsc_pkg::split_t   split_next, split_reg;

    // Stage one: quotient by 675 through a rounded-up reciprocal.
    assign x_next   = seconds_count[38:jsc_pkg::LOW_BITS];
    assign lo_next  = seconds_count[jsc_pkg::LOW_BITS-1:0];
    assign oor_next = (seconds_count < jsc_pkg::IN_LOW) || (seconds_count > jsc_pkg::IN_HIGH);
    assign day_prod = 65'(x_next) * 65'(jsc_pkg::RCP_DAY);
    assign zq_next  = day_prod[jsc_pkg::SH_DAY +: 23];

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            oor_reg <= oor_next;
            lo_reg  <= lo_next;
            x_reg   <= x_next;
            zq_reg  <= zq_next;
        end
    end

    // Stage two: remainder, weekday digit sum and the Gregorian correction operand.
    always_comb begin
        logic [31:0] zmul;
        logic [31:0] rem;
        logic [23:0] zp1;
        logic [24:0] ax_full;
        zmul = 32'(zq_reg) * 32'(jsc_pkg::DAY_ODD_DIV);
        rem  = x_reg - zmul;
        zp1  = {1'b0, zq_reg} + 24'd1;
        ax_full = {zq_reg, 2'b00} - 25'(jsc_pkg::ALPHA_OFFSET);
        split_next.oor  = oor_reg;
        split_next.greg = (zq_reg >= jsc_pkg::GREG_START);
        split_next.z    = zq_reg;
        split_next.ax   = ax_full[23:0];
        split_next.sod  = {rem[9:0], lo_reg};
        // Eight is one more than seven, so the octal digits sum to z + 1 modulo seven.
        split_next.wsum = '0;
        for (int i = 0; i < 8; i++) begin
            split_next.wsum = split_next.wsum + 6'(zp1[3*i +: 3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            split_reg <= split_next;
        end
    end

    assign split = split_reg;

endmodule

// ----- rtl/jsc_adjust.sv -----
// Stages three to five: calendar correction, time of day and weekday.
module jsc_adjust (
    input  logic             aclk,
    input  logic [2:0]       stage_en,
    input  jsc_pkg::split_t  split,
    output jsc_pkg::adj_t    adj
);

    // Stage three registers.
    logic              oor3_next, oor3_reg;
    logic              greg3_next, greg3_reg;
    logic [22:0]       z3_next, z3_reg;
    logic [16:0]       sod3_next, sod3_reg;
    logic [6:0]        alpha3_next, alpha3_reg;
    logic [10:0]       tmin3_next, tmin3_reg;
    logic [2:0]        wd3_next, wd3_reg;
    logic [48:0]       alpha_prod;
    logic [34:0]       sec_prod;

    // Stage four registers.
    logic              oor4_next, oor4_reg;
    logic [8:0]        z4_next, z4_reg;
    logic [22:0]       b4_next, b4_reg;
    logic [10:0]       tmin4_next, tmin4_reg;
    logic [4:0]        hour4_next, hour4_reg;
    logic [5:0]        sec4_next, sec4_reg;
    logic [2:0]        wd4_next, wd4_reg;
    logic [22:0]       hour_prod;

    jsc_pkg::adj_t     adj_next, adj_reg;

    assign alpha_prod = 49'(split.ax) * 49'(jsc_pkg::RCP_ALPHA);
    assign sec_prod   = 35'(split.sod) * 35'(jsc_pkg::RCP_SEC);

    always_comb begin
        logic [3:0] fold;
        oor3_next   = split.oor;
        greg3_next  = split.greg;
        z3_next     = split.z;
        sod3_next   = split.sod;
        alpha3_next = alpha_prod[jsc_pkg::SH_ALPHA +: 7];
        tmin3_next  = sec_prod[jsc_pkg::SH_SEC +: 11];
        fold = 4'(split.wsum[5:3]) + 4'(split.wsum[2:0]);
        if (fold >= 4'd14) begin
            wd3_next = 3'd1;
        end else if (fold >= 4'd7) begin
            wd3_next = 3'(fold - 4'd7) + 3'd1;
        end else begin
            wd3_next = 3'(fold) + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            oor3_reg   <= oor3_next;
            greg3_reg  <= greg3_next;
            z3_reg     <= z3_next;
            sod3_reg   <= sod3_next;
            alpha3_reg <= alpha3_next;
            tmin3_reg  <= tmin3_next;
            wd3_reg    <= wd3_next;
        end
    end

    assign hour_prod = 23'(tmin3_reg) * 23'(jsc_pkg::RCP_MIN);

    always_comb begin
        logic [7:0]  adj_days;
        logic [16:0] sec_full;
        adj_days   = 8'(alpha3_reg) + 8'd1 - 8'(alpha3_reg >> 2);
        oor4_next  = oor3_reg;
        z4_next    = z3_reg[8:0];
        b4_next    = z3_reg + (greg3_reg ? 23'(adj_days) : 23'd0) + 23'(jsc_pkg::B_BIAS);
        tmin4_next = tmin3_reg;
        hour4_next = hour_prod[jsc_pkg::SH_MIN +: 5];
        sec_full   = sod3_reg - 17'(tmin3_reg) * 17'(jsc_pkg::SECS_PER_MIN);
        sec4_next  = sec_full[5:0];
        wd4_next   = wd3_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            oor4_reg  <= oor4_next;
            z4_reg    <= z4_next;
            b4_reg    <= b4_next;
            tmin4_reg <= tmin4_next;
            hour4_reg <= hour4_next;
            sec4_reg  <= sec4_next;
            wd4_reg   <= wd4_next;
        end
    end

    always_comb begin
        logic [27:0] cx_full;
        logic [10:0] min_full;
        cx_full  = 28'(b4_reg) * 28'd20 - 28'(jsc_pkg::C_OFFSET);
        min_full = tmin4_reg - 11'(hour4_reg) * 11'(jsc_pkg::SECS_PER_MIN);
        adj_next.oor         = oor4_reg;
        adj_next.z_lo        = z4_reg;
        // B - D always lies below 512, so nine bits of B are enough downstream.
        adj_next.b_lo        = b4_reg[8:0];
        adj_next.cx          = cx_full[26:0];
        adj_next.tod.hour    = hour4_reg;
        adj_next.tod.minute  = min_full[5:0];
        adj_next.tod.second  = sec4_reg;
        adj_next.tod.weekday = wd4_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            adj_reg <= adj_next;
        end
    end

    assign adj = adj_reg;

endmodule

// ----- rtl/jsc_date.sv -----
// Stages six to nine: year, month and day from the corrected day count.
module jsc_date (
    input  logic            aclk,
    input  logic [3:0]      stage_en,
    input  jsc_pkg::adj_t   adj,
    output jsc_pkg::ymd_t   ymd
);

    logic              oor6_next, oor6_reg, oor7_reg, oor8_reg;
    logic [8:0]        z6_next, z6_reg, z7_reg, z8_reg;
    logic [8:0]        b6_next, b6_reg;
    logic [14:0]       c6_next, c6_reg, c7_reg, c8_reg;
    jsc_pkg::tod_t     tod6_next, tod6_reg, tod7_reg, tod8_reg;
    logic [54:0]       c_prod;
    logic [8:0]        bd7_next, bd7_reg, bd8_reg;
    logic [25:0]       d_prod;
    logic [3:0]        e8_next, e8_reg;
    logic [32:0]       e_prod;
    jsc_pkg::ymd_t     ymd_next, ymd_reg;

    // Stage six: year count C.
    assign c_prod    = 55'(adj.cx) * 55'(jsc_pkg::RCP_C);
    assign c6_next   = c_prod[jsc_pkg::SH_C +: 15];
    assign oor6_next = adj.oor;
    assign z6_next   = adj.z_lo;
    assign b6_next   = adj.b_lo;
    assign tod6_next = adj.tod;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            oor6_reg <= oor6_next;
            z6_reg   <= z6_next;
            b6_reg   <= b6_next;
            c6_reg   <= c6_next;
            tod6_reg <= tod6_next;
        end
    end

    // Stage seven: days left after the whole years, B - floor(1461 C / 4).
    assign d_prod   = 26'(c6_reg) * 26'd1461;
    assign bd7_next = b6_reg - d_prod[10:2];

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            oor7_reg <= oor6_reg;
            z7_reg   <= z6_reg;
            c7_reg   <= c6_reg;
            tod7_reg <= tod6_reg;
            bd7_reg  <= bd7_next;
        end
    end

    // Stage eight: month index E.
    assign e_prod  = 33'(bd7_reg) * 33'(jsc_pkg::RCP_E);
    assign e8_next = e_prod[jsc_pkg::SH_E +: 4];

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            oor8_reg <= oor7_reg;
            z8_reg   <= z7_reg;
            c8_reg   <= c7_reg;
            tod8_reg <= tod7_reg;
            bd8_reg  <= bd7_reg;
            e8_reg   <= e8_next;
        end
    end

    // Stage nine: day, month and year.
    always_comb begin
        logic [8:0]  day_full;
        logic [3:0]  mon;
        logic [14:0] yr_full;
        day_full = bd8_reg - jsc_pkg::DAY_OFFSET[e8_reg];
        mon      = (e8_reg < 4'd14) ? e8_reg - 4'd1 : e8_reg - 4'd13;
        yr_full  = c8_reg - ((mon > 4'd2) ? 15'(jsc_pkg::YEAR_LATE) : 15'(jsc_pkg::YEAR_EARLY));
        ymd_next.oor   = oor8_reg;
        ymd_next.z_lo  = z8_reg;
        ymd_next.year  = yr_full[13:0];
        ymd_next.month = mon;
        ymd_next.day   = day_full[4:0];
        ymd_next.tod   = tod8_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            ymd_reg <= ymd_next;
        end
    end

    assign ymd = ymd_reg;

endmodule

// ----- rtl/jsc_doy.sv -----
// Stages ten and eleven: day of year against the Gregorian January 1, and the output register.
module jsc_doy (
    input  logic              aclk,
    input  logic [1:0]        stage_en,
    input  jsc_pkg::ymd_t     ymd,
    output jsc_pkg::result_t  result
);

    jsc_pkg::ymd_t     ymd10_next, ymd10_reg;
    logic [7:0]        q10_next, q10_reg;
    logic [8:0]        p10_next, p10_reg;
    logic [14:0]       cent_sum;
    logic [30:0]       cent_prod;
    logic [25:0]       leap_prod;
    jsc_pkg::result_t  result_next, result_reg;

    // Stage ten: the century term and the four-year term of January 1.
    assign cent_sum   = 15'(ymd.year) + 15'(jsc_pkg::CENT_OFFSET);
    assign cent_prod  = 31'(cent_sum) * 31'(jsc_pkg::RCP_CENT);
    assign q10_next   = cent_prod[jsc_pkg::SH_CENT +: 8];
    assign leap_prod  = 26'(15'(ymd.year) + 15'(jsc_pkg::LEAP_OFFSET)) * 26'd1461;
    assign p10_next   = leap_prod[10:2];
    assign ymd10_next = ymd;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            ymd10_reg <= ymd10_next;
            q10_reg   <= q10_next;
            p10_reg   <= p10_next;
        end
    end

    // Stage eleven: everything is taken modulo 512, which is all the field keeps.
    always_comb begin
        logic [9:0] q3;
        logic [8:0] doy;
        q3  = 10'(q10_reg) * 10'd3;
        doy = ymd10_reg.z_lo - p10_reg + 9'(q3 >> 2) + jsc_pkg::DOY_BIAS;
        result_next.oor = ymd10_reg.oor;
        if (ymd10_reg.oor) begin
            result_next.year        = '0;
            result_next.month       = '0;
            result_next.day         = '0;
            result_next.tod         = '0;
            result_next.day_of_year = '0;
        end else begin
            result_next.year        = ymd10_reg.year;
            result_next.month       = ymd10_reg.month;
            result_next.day         = ymd10_reg.day;
            result_next.tod         = ymd10_reg.tod;
            result_next.day_of_year = doy;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- rtl/julian_seconds_to_calendar_unit.sv -----
// An accepted request passes through all eleven register stages before it shows at m_tvalid.
// Throughput: one request per cycle unless all stages are full and the output is stalled;
// eleven register stages, each with at most two multipliers by constants.
// A stall holds each full stage after the last empty one in place; the stages before it keep filling.
// Reset (aresetn low at a clock edge) clears the stage valid bits; data registers keep contents.
module julian_seconds_to_calendar_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [38:0] seconds_count, [39] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // year, month, day, hour, minute, second, weekday,
                                   // day_of_year from bit 0 up, [55:52] zero
    output logic        m_tuser    // out_of_range
);

    localparam int NSTG = jsc_pkg::STAGES;

    logic [NSTG-1:0]   valid_reg, valid_next, valid_in, ready;
    jsc_pkg::split_t   split;
    jsc_pkg::adj_t     adj;
    jsc_pkg::ymd_t     ymd;
    jsc_pkg::result_t  result;

    // A stage may load when it is empty or when some stage after it can move.
    always_comb begin
        for (int i = 0; i < NSTG; i++) begin
            ready[i] = m_tready || ((valid_reg | ~({NSTG{1'b1}} << i)) != {NSTG{1'b1}});
        end
    end

    assign valid_in   = {valid_reg[NSTG-2:0], s_tvalid};
    assign valid_next = (ready & valid_in) | (~ready & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[NSTG-1];

    jsc_day_split u_day_split (
        .aclk          (aclk),
        .stage_en      (ready[1:0]),
        .seconds_count (s_tdata[38:0]),
        .split         (split)
    );

    jsc_adjust u_adjust (
        .aclk     (aclk),
        .stage_en (ready[4:2]),
        .split    (split),
        .adj      (adj)
    );

    jsc_date u_date (
        .aclk     (aclk),
        .stage_en (ready[8:5]),
        .adj      (adj),
        .ymd      (ymd)
    );

    jsc_doy u_doy (
        .aclk     (aclk),
        .stage_en (ready[10:9]),
        .ymd      (ymd),
        .result   (result)
    );

    assign m_tdata = {4'b0000, result.day_of_year, result.tod.weekday, result.tod.second,
                      result.tod.minute, result.tod.hour, result.day, result.month,
                      result.year};
    assign m_tuser = result.oor;

    // The input side can only be blocked when every stage is full and the output is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input blocked while the pipeline still has room");

    // A flagged result carries no date or time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[51:0] == 52'd0))
        else $error("out-of-range result has nonzero fields");

    // A valid date has its calendar and clock fields within their ranges (the day only against zero).
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
            (m_tdata[13:0] != 14'd0) && (m_tdata[13:0] <= 14'd9999) &&
            (m_tdata[17:14] != 4'd0) && (m_tdata[17:14] <= 4'd12) &&
            (m_tdata[22:18] != 5'd0) && (m_tdata[27:23] <= 5'd23) &&
            (m_tdata[33:28] <= 6'd59) && (m_tdata[39:34] <= 6'd59) &&
            (m_tdata[42:40] != 3'd0))
        else $error("calendar or clock field out of range");

endmodule
